// ===== rtl/core/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants of the sphere cell classifier
// Field widths, register indexes, class codes and the pipeline side-band
// structures that travel between the classifier's stages.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int MAG_WIDTH   = COORD_WIDTH - 1;   // radius, bands, wall distance
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;   // cell minus center
  localparam int ABS_WIDTH   = COORD_WIDTH;       // |cell minus center|
  localparam int SQ_WIDTH    = 2 * ABS_WIDTH;
  localparam int SUM_WIDTH   = SQ_WIDTH + 2;
  localparam int RAD_WIDTH   = 2 * MAG_WIDTH;     // squared distance of inside cells
  localparam int ROOT_WIDTH  = MAG_WIDTH;
  localparam int SQ_STEPS    = ROOT_WIDTH;
  localparam int REM_WIDTH   = ROOT_WIDTH + 2;
  localparam int FRAC_BITS   = 16;
  localparam int QUO_WIDTH   = FRAC_BITS + 1;
  localparam int NUM_WIDTH   = ABS_WIDTH + FRAC_BITS + 1;
  localparam int NORM_WIDTH  = 18;
  localparam int CFG_IDX_WIDTH = 3;

  localparam logic [QUO_WIDTH-1:0] NORMAL_ONE = QUO_WIDTH'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    CLASS_FLUID = 2'd0,
    CLASS_GHOST = 2'd1,
    CLASS_BODY  = 2'd2
  } cell_class_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_RADIUS   = 3'd3,
    REG_BAND_X   = 3'd4,
    REG_BAND_Y   = 3'd5,
    REG_BAND_Z   = 3'd6
  } reg_idx_t;

  // Side band of the front end and the square root chain.
  typedef struct packed {
    logic                           last;
    logic                           in_sphere;
    logic [2:0]                     neg;
    logic [2:0][ABS_WIDTH-1:0]      mag;
  } side_t;

  // Side band of the normal divider chain.
  typedef struct packed {
    logic                  last;
    cell_class_t           cls;
    logic [MAG_WIDTH-1:0]  gap;
    logic [2:0]            neg;
  } post_t;

endpackage

// ===== rtl/core/scc_in_if.sv =====
// ----------------------------------------------------------------------------
// scc_in_if: cell input channel
// Valid/ready channel carrying one cell center and its end-of-region flag.
// ----------------------------------------------------------------------------
interface scc_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [scc_pkg::COORD_WIDTH-1:0]   cell_x;
  logic signed [scc_pkg::COORD_WIDTH-1:0]   cell_y;
  logic signed [scc_pkg::COORD_WIDTH-1:0]   cell_z;
  logic                                     last_cell;

  modport source (output valid, cell_x, cell_y, cell_z, last_cell, input ready);
  modport sink   (input valid, cell_x, cell_y, cell_z, last_cell, output ready);
endinterface

// ===== rtl/core/scc_out_if.sv =====
// ----------------------------------------------------------------------------
// scc_out_if: classification result channel
// Valid/ready channel carrying class, wall distance and unit normal.
// ----------------------------------------------------------------------------
interface scc_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               cell_class;
  logic [scc_pkg::MAG_WIDTH-1:0]            wall_distance;
  logic signed [scc_pkg::NORM_WIDTH-1:0]    normal_x;
  logic signed [scc_pkg::NORM_WIDTH-1:0]    normal_y;
  logic signed [scc_pkg::NORM_WIDTH-1:0]    normal_z;
  logic                                     last_out;

  modport source (output valid, cell_class, wall_distance, normal_x, normal_y, normal_z,
                  last_out, input ready);
  modport sink   (input valid, cell_class, wall_distance, normal_x, normal_y, normal_z,
                  last_out, output ready);
endinterface

// ===== rtl/core/scc_sqrt_step.sv =====
// ----------------------------------------------------------------------------
// scc_sqrt_step: one stage of the pipelined integer square root
// Retires one root bit per stage from the top two radicand bits.
// ----------------------------------------------------------------------------
module scc_sqrt_step (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                valid_in,
  input  logic [scc_pkg::RAD_WIDTH-1:0]       rad_in,
  input  logic [scc_pkg::ROOT_WIDTH-1:0]      root_in,
  input  logic [scc_pkg::REM_WIDTH-1:0]       rem_in,
  input  scc_pkg::side_t                      side_in,
  output logic                                valid_out,
  output logic [scc_pkg::RAD_WIDTH-1:0]       rad_out,
  output logic [scc_pkg::ROOT_WIDTH-1:0]      root_out,
  output logic [scc_pkg::REM_WIDTH-1:0]       rem_out,
  output scc_pkg::side_t                      side_out
);

  logic                               valid_r;
  logic [scc_pkg::RAD_WIDTH-1:0]      rad_r, rad_nxt;
  logic [scc_pkg::ROOT_WIDTH-1:0]     root_r, root_nxt;
  logic [scc_pkg::REM_WIDTH-1:0]      rem_r, rem_nxt;
  scc_pkg::side_t                     side_r;
  logic [scc_pkg::REM_WIDTH+1:0]      work, trial;

  always_comb begin
    work  = {rem_in, rad_in[scc_pkg::RAD_WIDTH-1 -: 2]};
    trial = {2'b00, root_in, 2'b01};
    rad_nxt = rad_in << 2;
    if (work >= trial) begin
      rem_nxt  = scc_pkg::REM_WIDTH'(work - trial);
      root_nxt = {root_in[scc_pkg::ROOT_WIDTH-2:0], 1'b1};
    end else begin
      rem_nxt  = scc_pkg::REM_WIDTH'(work);
      root_nxt = {root_in[scc_pkg::ROOT_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign rad_out   = rad_r;
  assign root_out  = root_r;
  assign rem_out   = rem_r;
  assign side_out  = side_r;

endmodule

// ===== rtl/core/scc_div_step.sv =====
// ----------------------------------------------------------------------------
// scc_div_step: one stage of the three-lane normal divider
// Each lane retires one quotient bit of |d| * 2^16 / r per stage.
// ----------------------------------------------------------------------------
module scc_div_step (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            en,
  input  logic                                            valid_in,
  input  logic [scc_pkg::ROOT_WIDTH-1:0]                  div_in,
  input  logic [2:0][scc_pkg::ROOT_WIDTH-1:0]             rem_in,
  input  logic [2:0][scc_pkg::QUO_WIDTH-1:0]              low_in,
  input  logic [2:0][scc_pkg::QUO_WIDTH-1:0]              quo_in,
  input  scc_pkg::post_t                                  post_in,
  output logic                                            valid_out,
  output logic [scc_pkg::ROOT_WIDTH-1:0]                  div_out,
  output logic [2:0][scc_pkg::ROOT_WIDTH-1:0]             rem_out,
  output logic [2:0][scc_pkg::QUO_WIDTH-1:0]              low_out,
  output logic [2:0][scc_pkg::QUO_WIDTH-1:0]              quo_out,
  output scc_pkg::post_t                                  post_out
);

  logic                                         valid_r;
  logic [scc_pkg::ROOT_WIDTH-1:0]               div_r;
  logic [2:0][scc_pkg::ROOT_WIDTH-1:0]          rem_r, rem_nxt;
  logic [2:0][scc_pkg::QUO_WIDTH-1:0]           low_r, low_nxt, quo_r, quo_nxt;
  scc_pkg::post_t                               post_r;
  logic [2:0][scc_pkg::ROOT_WIDTH:0]            work;
  logic [2:0]                                   ge;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      work[i]    = {rem_in[i], low_in[i][scc_pkg::QUO_WIDTH-1]};
      ge[i]      = work[i] >= {1'b0, div_in};
      rem_nxt[i] = ge[i] ? scc_pkg::ROOT_WIDTH'(work[i] - {1'b0, div_in})
                         : scc_pkg::ROOT_WIDTH'(work[i]);
      low_nxt[i] = low_in[i] << 1;
      quo_nxt[i] = {quo_in[i][scc_pkg::QUO_WIDTH-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r  <= div_in;
      rem_r  <= rem_nxt;
      low_r  <= low_nxt;
      quo_r  <= quo_nxt;
      post_r <= post_in;
    end
  end

  assign valid_out = valid_r;
  assign div_out   = div_r;
  assign rem_out   = rem_r;
  assign low_out   = low_r;
  assign quo_out   = quo_r;
  assign post_out  = post_r;

endmodule

// ===== rtl/core/sphere_cell_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// sphere_cell_classifier_unit: streaming sphere ghost-cell classifier
// Classifies each cell center as fluid, ghost or body against a sphere and
// produces wall distance and unit normal for ghost cells.
// ----------------------------------------------------------------------------
// Usage: cell centers arrive as beats on in_ch, one result beat per cell leaves
// on out_ch in the same order. Sphere center, radius and per-axis ghost bands
// are written through cfg_we/cfg_index/cfg_data while no cell is in flight.
// The block is a single pipeline of 46 register stages: three front stages
// (offset, squares, sum and inside test), 23 square root stages producing one
// root bit each, two stages for the ghost band products and the compare,
// 17 divider stages producing one normal bit per lane, and the output
// register. One beat is accepted in every cycle while the receiver takes
// results. A stall on out_ch freezes all stages together; in_ch.ready drops
// in the same cycle, so nothing is dropped or repeated. Empty stages freeze
// as well, so a waiting beat in the output register blocks the input even
// when the pipeline holds bubbles.
// Reset clears all stage valid bits and loads the register defaults: center
// at the origin, radius 2^19, all bands zero.
// ----------------------------------------------------------------------------
module sphere_cell_classifier_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  scc_in_if.sink                              in_ch,
  scc_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [scc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [scc_pkg::COORD_WIDTH-1:0]     cfg_data
);

  localparam int CW = scc_pkg::COORD_WIDTH;
  localparam int MW = scc_pkg::MAG_WIDTH;
  localparam int AW = scc_pkg::ABS_WIDTH;
  localparam int RW = scc_pkg::ROOT_WIDTH;
  localparam int QW = scc_pkg::QUO_WIDTH;

  // Configuration registers.
  logic [CW-1:0] center_r [3];
  logic [MW-1:0] radius_r;
  logic [MW-1:0] band_r   [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        center_r[i] <= '0;
        band_r[i]   <= '0;
      end
      radius_r <= MW'(1) << (MW - 4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        scc_pkg::REG_CENTER_X: center_r[0] <= cfg_data;
        scc_pkg::REG_CENTER_Y: center_r[1] <= cfg_data;
        scc_pkg::REG_CENTER_Z: center_r[2] <= cfg_data;
        scc_pkg::REG_RADIUS:   radius_r    <= cfg_data[MW-1:0];
        scc_pkg::REG_BAND_X:   band_r[0]   <= cfg_data[MW-1:0];
        scc_pkg::REG_BAND_Y:   band_r[1]   <= cfg_data[MW-1:0];
        scc_pkg::REG_BAND_Z:   band_r[2]   <= cfg_data[MW-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances when the output register is free or drained.
  logic out_v_r;
  logic en;
  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: offset from the center, split into sign and magnitude.
  logic [CW-1:0]               cell_pos [3];
  logic [scc_pkg::DIFF_WIDTH-1:0] diff [3];
  logic [scc_pkg::DIFF_WIDTH-1:0] absd [3];
  scc_pkg::side_t              side1_nxt, side1_r;
  logic                        v1_r;

  assign cell_pos[0] = in_ch.cell_x;
  assign cell_pos[1] = in_ch.cell_y;
  assign cell_pos[2] = in_ch.cell_z;

  always_comb begin
    side1_nxt        = '0;
    side1_nxt.last   = in_ch.last_cell;
    for (int i = 0; i < 3; i++) begin
      diff[i] = {cell_pos[i][CW-1], cell_pos[i]} - {center_r[i][CW-1], center_r[i]};
      absd[i] = diff[i][scc_pkg::DIFF_WIDTH-1] ? (scc_pkg::DIFF_WIDTH'(0) - diff[i]) : diff[i];
      side1_nxt.neg[i] = diff[i][scc_pkg::DIFF_WIDTH-1];
      side1_nxt.mag[i] = absd[i][AW-1:0];
    end
  end

  // Stage 2: squares of the offsets and of the radius.
  logic [scc_pkg::SQ_WIDTH-1:0]  sq2_r [3];
  logic [scc_pkg::RAD_WIDTH-1:0] rr2_r;
  scc_pkg::side_t                side2_r;
  logic                          v2_r;

  // Stage 3: squared distance and the inside test.
  logic [scc_pkg::SUM_WIDTH-1:0] r2;
  logic                          inside3;
  scc_pkg::side_t                side3_r, side3_nxt;
  logic [scc_pkg::RAD_WIDTH-1:0] rad3_r;
  logic                          v3_r;

  always_comb begin
    r2 = scc_pkg::SUM_WIDTH'(sq2_r[0]) + scc_pkg::SUM_WIDTH'(sq2_r[1])
       + scc_pkg::SUM_WIDTH'(sq2_r[2]);
    inside3 = r2 < scc_pkg::SUM_WIDTH'(rr2_r);
    side3_nxt           = side2_r;
    side3_nxt.in_sphere = inside3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side1_nxt;
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= side1_r.mag[i] * side1_r.mag[i];
      end
      rr2_r   <= radius_r * radius_r;
      side2_r <= side1_r;
      side3_r <= side3_nxt;
      rad3_r  <= inside3 ? r2[scc_pkg::RAD_WIDTH-1:0] : '0;
    end
  end

  // Square root chain: one root bit per stage.
  logic                           sq_v    [scc_pkg::SQ_STEPS+1];
  logic [scc_pkg::RAD_WIDTH-1:0]  sq_rad  [scc_pkg::SQ_STEPS+1];
  logic [RW-1:0]                  sq_root [scc_pkg::SQ_STEPS+1];
  logic [scc_pkg::REM_WIDTH-1:0]  sq_rem  [scc_pkg::SQ_STEPS+1];
  scc_pkg::side_t                 sq_side [scc_pkg::SQ_STEPS+1];

  assign sq_v[0]    = v3_r;
  assign sq_rad[0]  = rad3_r;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_side[0] = side3_r;

  for (genvar k = 0; k < scc_pkg::SQ_STEPS; k++) begin : g_sqrt
    scc_sqrt_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (sq_v[k]),
      .rad_in   (sq_rad[k]),
      .root_in  (sq_root[k]),
      .rem_in   (sq_rem[k]),
      .side_in  (sq_side[k]),
      .valid_out(sq_v[k+1]),
      .rad_out  (sq_rad[k+1]),
      .root_out (sq_root[k+1]),
      .rem_out  (sq_rem[k+1]),
      .side_out (sq_side[k+1])
    );
  end

  // Stage 4: wall gap and the band products of the ghost test.
  logic [RW-1:0]         root_s;
  scc_pkg::side_t        side_s;
  logic [MW-1:0]         gap4_nxt;
  logic [MW-1:0]         gap4_r;
  logic [RW-1:0]         r4_r;
  logic [MW+AW-1:0]      pgap4_r  [3];
  logic [MW+RW-1:0]      pband4_r [3];
  scc_pkg::side_t        side4_r;
  logic                  v4_r;

  assign root_s   = sq_root[scc_pkg::SQ_STEPS];
  assign side_s   = sq_side[scc_pkg::SQ_STEPS];
  assign gap4_nxt = radius_r - root_s;

  // Stage 5: ghost decision and divider setup.
  logic                              ghost5;
  scc_pkg::cell_class_t              cls5;
  logic [scc_pkg::NUM_WIDTH-1:0]     num5 [3];
  logic [2:0][RW-1:0]                rem5_nxt;
  logic [2:0][QW-1:0]                low5_nxt;
  logic [2:0][RW-1:0]                rem5_r;
  logic [2:0][QW-1:0]                low5_r;
  scc_pkg::post_t                    post5_nxt, post5_r;
  logic [RW-1:0]                     r5_r;
  logic                              v5_r;

  always_comb begin
    ghost5 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (pgap4_r[i] < (MW+AW)'(pband4_r[i])) ghost5 = 1'b1;
      num5[i] = scc_pkg::NUM_WIDTH'({side4_r.mag[i], {scc_pkg::FRAC_BITS{1'b0}}})
              + scc_pkg::NUM_WIDTH'(r4_r >> 1);
      rem5_nxt[i] = num5[i][QW +: RW];
      low5_nxt[i] = num5[i][QW-1:0];
    end
    priority if (!side4_r.in_sphere) begin
      cls5 = scc_pkg::CLASS_FLUID;
    end else if (ghost5 && (r4_r != '0)) begin
      cls5 = scc_pkg::CLASS_GHOST;
    end else begin
      cls5 = scc_pkg::CLASS_BODY;
    end
    post5_nxt.last = side4_r.last;
    post5_nxt.cls  = cls5;
    post5_nxt.gap  = gap4_r;
    post5_nxt.neg  = side4_r.neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= sq_v[scc_pkg::SQ_STEPS];
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gap4_r  <= gap4_nxt;
      r4_r    <= root_s;
      side4_r <= side_s;
      for (int i = 0; i < 3; i++) begin
        pgap4_r[i]  <= gap4_nxt * side_s.mag[i];
        pband4_r[i] <= band_r[i] * root_s;
      end
      rem5_r  <= rem5_nxt;
      low5_r  <= low5_nxt;
      post5_r <= post5_nxt;
      r5_r    <= r4_r;
    end
  end

  // Divider chain: one normal bit per lane and stage.
  logic                   dv_v    [QW+1];
  logic [RW-1:0]          dv_div  [QW+1];
  logic [2:0][RW-1:0]     dv_rem  [QW+1];
  logic [2:0][QW-1:0]     dv_low  [QW+1];
  logic [2:0][QW-1:0]     dv_quo  [QW+1];
  scc_pkg::post_t         dv_post [QW+1];

  assign dv_v[0]    = v5_r;
  assign dv_div[0]  = r5_r;
  assign dv_rem[0]  = rem5_r;
  assign dv_low[0]  = low5_r;
  assign dv_quo[0]  = '0;
  assign dv_post[0] = post5_r;

  for (genvar k = 0; k < QW; k++) begin : g_div
    scc_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (dv_v[k]),
      .div_in   (dv_div[k]),
      .rem_in   (dv_rem[k]),
      .low_in   (dv_low[k]),
      .quo_in   (dv_quo[k]),
      .post_in  (dv_post[k]),
      .valid_out(dv_v[k+1]),
      .div_out  (dv_div[k+1]),
      .rem_out  (dv_rem[k+1]),
      .low_out  (dv_low[k+1]),
      .quo_out  (dv_quo[k+1]),
      .post_out (dv_post[k+1])
    );
  end

  // Output register: saturate, apply sign, zero the non-ghost fields.
  scc_pkg::post_t                post_f;
  logic                          ghost_f;
  logic [QW-1:0]                 qsat [3];
  logic [scc_pkg::NORM_WIDTH-1:0] nmag [3];
  logic [scc_pkg::NORM_WIDTH-1:0] norm_nxt [3];
  logic [scc_pkg::NORM_WIDTH-1:0] norm_r [3];
  logic [1:0]                    cls_r;
  logic [MW-1:0]                 wall_r;
  logic                          last_r;

  assign post_f  = dv_post[QW];
  assign ghost_f = post_f.cls == scc_pkg::CLASS_GHOST;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qsat[i] = (dv_quo[QW][i] > scc_pkg::NORMAL_ONE) ? scc_pkg::NORMAL_ONE : dv_quo[QW][i];
      nmag[i] = scc_pkg::NORM_WIDTH'(qsat[i]);
      if (!ghost_f) begin
        norm_nxt[i] = '0;
      end else if (post_f.neg[i]) begin
        norm_nxt[i] = scc_pkg::NORM_WIDTH'(0) - nmag[i];
      end else begin
        norm_nxt[i] = nmag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_r  <= post_f.cls;
      wall_r <= ghost_f ? post_f.gap : '0;
      last_r <= post_f.last;
      for (int i = 0; i < 3; i++) begin
        norm_r[i] <= norm_nxt[i];
      end
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.cell_class    = cls_r;
  assign out_ch.wall_distance = wall_r;
  assign out_ch.normal_x      = norm_r[0];
  assign out_ch.normal_y      = norm_r[1];
  assign out_ch.normal_z      = norm_r[2];
  assign out_ch.last_out      = last_r;

  // A result that is not ghost carries no wall distance and no normal.
  a_non_ghost_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (cls_r != scc_pkg::CLASS_GHOST) |->
      (wall_r == '0) && (norm_r[0] == '0) && (norm_r[1] == '0) && (norm_r[2] == '0))
    else $error("non-ghost result carries geometry");

  // A stalled output holds its result.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(cls_r) && $stable(wall_r)
      && $stable(last_r))
    else $error("stalled result changed");

  // The pipeline takes no new cell while the output is blocked.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted during stall");

  // A square root result stays below the radius for an inside cell.
  a_root_below_radius: assert property (@(posedge clk) disable iff (!rst_n)
    sq_v[scc_pkg::SQ_STEPS] && sq_side[scc_pkg::SQ_STEPS].in_sphere |->
      root_s < radius_r)
    else $error("root not below radius");

endmodule
